>>> rtl/rbm_pkg.sv
// shared types and constants of the rsa modular exponentiation block
package rbm_pkg;

  localparam int WORD_W    = 63;
  localparam int MSG_W     = 32;
  localparam int COUNT_W   = 3;
  localparam int CFG_IDX_W = 2;
  localparam int BYTE_W    = 8;
  localparam int LANE_STEP = 16;
  localparam int STEP_W    = $clog2(WORD_W);

  localparam int BYTES_PER_BLOCK_DEF = 4;
  localparam int MODULUS_BITS_DEF    = 63;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PUBLIC_EXP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIVATE_EXP = 2'd2;

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_NEXT,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    PH_REDUCE,
    PH_SQUARE,
    PH_MULT
  } phase_e;

endpackage

>>> rtl/rbm_if.sv
// valid/ready channel interfaces for input items, results and register writes
interface rbm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [rbm_pkg::MSG_W-1:0]     message_bytes;
  logic [rbm_pkg::COUNT_W-1:0]   valid_bytes;
  logic [rbm_pkg::WORD_W-1:0]    cipher_in;

  modport source (output valid, command, message_bytes, valid_bytes, cipher_in, input ready);
  modport sink   (input valid, command, message_bytes, valid_bytes, cipher_in, output ready);
endinterface

interface rbm_out_if;
  logic                       valid;
  logic                       ready;
  logic [rbm_pkg::WORD_W-1:0] cipher_out;
  logic [rbm_pkg::MSG_W-1:0]  plain_out;

  modport source (output valid, cipher_out, plain_out, input ready);
  modport sink   (input valid, cipher_out, plain_out, output ready);
endinterface

interface rbm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rbm_pkg::CFG_IDX_W-1:0] index;
  logic [rbm_pkg::WORD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/rsa_block_modexp_unit.sv
// rsa modular exponentiation: square and multiply on one bit-serial modular multiplier
// one multiplier pass reduces the base, then for each exponent bit from the msb the
//   multiplier squares and, for a set bit, multiplies by the base
// throughput: one item at a time; the next input is taken once the result sits in the output
//   register, a zero modulus skips the multiplier and gives a zero result
// reset: rst_ni async active low; modulus resets to 1, both exponents to 0, no result pending
module rsa_block_modexp_unit #(
  parameter int BYTES_PER_BLOCK = rbm_pkg::BYTES_PER_BLOCK_DEF,
  parameter int MODULUS_BITS    = rbm_pkg::MODULUS_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rbm_cfg_if.sink    cfg_i,
  rbm_in_if.sink     in_i,
  rbm_out_if.source  out_o
);

  localparam int W = rbm_pkg::WORD_W;
  localparam logic [W-1:0] ModMask = {W{1'b1}} >> (W - MODULUS_BITS);
  localparam logic [rbm_pkg::COUNT_W-1:0] MaxBytes = rbm_pkg::COUNT_W'(BYTES_PER_BLOCK);
  localparam logic [rbm_pkg::STEP_W-1:0] LastStep = rbm_pkg::STEP_W'(W - 1);

  // configuration registers
  logic [W-1:0] modulus_q, public_exp_q, private_exp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q     <= W'(1);
      public_exp_q  <= '0;
      private_exp_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        rbm_pkg::CFG_MODULUS:     modulus_q     <= cfg_i.data;
        rbm_pkg::CFG_PUBLIC_EXP:  public_exp_q  <= cfg_i.data;
        rbm_pkg::CFG_PRIVATE_EXP: private_exp_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  logic [W-1:0] n;
  logic [W:0]   n2;
  logic [W-1:0] one;
  assign n   = modulus_q & ModMask;
  assign n2  = {n, 1'b0};
  assign one = (n == W'(1)) ? '0 : W'(1);

  // control and datapath registers
  rbm_pkg::state_e state_q, state_d;
  rbm_pkg::phase_e phase_q, phase_d;
  logic [rbm_pkg::STEP_W-1:0] step_q, step_d;
  logic [rbm_pkg::STEP_W-1:0] iter_q, iter_d;
  logic out_valid_q, out_valid_d;
  logic cmd_q, cmd_d;
  logic [W-1:0] acc_q, acc_d;
  logic [W-1:0] op_a_q, op_a_d;
  logic [W-1:0] op_b_q, op_b_d;
  logic [W-1:0] base_q, base_d;
  logic [W-1:0] r_q, r_d;
  logic [W-1:0] exp_q, exp_d;
  logic [W-1:0] cipher_q, cipher_d;
  logic [rbm_pkg::MSG_W-1:0] plain_q, plain_d;

  // input word packing, byte k at bit 16k
  logic [rbm_pkg::COUNT_W-1:0] count_sat;
  logic [W-1:0] packed_word;
  logic [W-1:0] in_base;

  always_comb begin
    count_sat   = (in_i.valid_bytes > MaxBytes) ? MaxBytes : in_i.valid_bytes;
    packed_word = '0;
    for (int k = 0; k < BYTES_PER_BLOCK; k++) begin
      if (rbm_pkg::COUNT_W'(k) < count_sat) begin
        packed_word[rbm_pkg::LANE_STEP*k +: rbm_pkg::BYTE_W] =
          in_i.message_bytes[rbm_pkg::BYTE_W*k +: rbm_pkg::BYTE_W];
      end
    end
    in_base = (in_i.command == rbm_pkg::CMD_DECRYPT) ? in_i.cipher_in : packed_word;
  end

  // one multiplier step: acc = (2*acc + bit*a) mod n, sum stays below 3n
  logic [W+1:0] sum;
  logic [W+2:0] diff1, diff2;
  logic [W-1:0] step_res;

  assign sum   = {1'b0, acc_q, 1'b0} + {2'b0, (op_b_q[W-1] ? op_a_q : '0)};
  assign diff1 = {1'b0, sum} - {3'b0, n};
  assign diff2 = {1'b0, sum} - {2'b0, n2};
  assign step_res = !diff2[W+2] ? diff2[W-1:0] : (!diff1[W+2] ? diff1[W-1:0] : sum[W-1:0]);

  // unpacking of the decrypted word, byte j from bit 16j
  logic [rbm_pkg::MSG_W-1:0] plain_word;
  always_comb begin
    plain_word = '0;
    for (int k = 0; k < BYTES_PER_BLOCK; k++) begin
      plain_word[rbm_pkg::BYTE_W*k +: rbm_pkg::BYTE_W] =
        r_q[rbm_pkg::LANE_STEP*k +: rbm_pkg::BYTE_W];
    end
  end

  logic in_xfer, out_xfer, out_free, iter_end;
  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_o.valid && out_o.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign iter_end = (phase_q == rbm_pkg::PH_MULT) ||
                    (phase_q == rbm_pkg::PH_SQUARE && !exp_q[W-1]);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rbm_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = (n == '0) ? rbm_pkg::ST_DONE : rbm_pkg::ST_RUN;
        end
      end
      rbm_pkg::ST_RUN: begin
        if (step_q == LastStep) begin
          state_d = rbm_pkg::ST_NEXT;
        end
      end
      rbm_pkg::ST_NEXT: begin
        if (iter_end && iter_q == LastStep) begin
          state_d = rbm_pkg::ST_DONE;
        end else begin
          state_d = rbm_pkg::ST_RUN;
        end
      end
      rbm_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = rbm_pkg::ST_IDLE;
        end
      end
      default: state_d = rbm_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_i.ready  = (state_q == rbm_pkg::ST_IDLE);
    phase_d     = phase_q;
    step_d      = step_q;
    iter_d      = iter_q;
    out_valid_d = out_valid_q && !out_xfer;
    cmd_d       = cmd_q;
    acc_d       = acc_q;
    op_a_d      = op_a_q;
    op_b_d      = op_b_q;
    base_d      = base_q;
    r_d         = r_q;
    exp_d       = exp_q;
    cipher_d    = cipher_q;
    plain_d     = plain_q;
    case (state_q)
      rbm_pkg::ST_IDLE: begin
        if (in_xfer) begin
          cmd_d   = in_i.command;
          exp_d   = (in_i.command == rbm_pkg::CMD_DECRYPT) ? private_exp_q : public_exp_q;
          // base reduction runs as one * base through the multiplier
          op_a_d  = one;
          op_b_d  = in_base;
          acc_d   = '0;
          step_d  = '0;
          iter_d  = '0;
          phase_d = rbm_pkg::PH_REDUCE;
          r_d     = (n == '0) ? '0 : one;
        end
      end
      rbm_pkg::ST_RUN: begin
        acc_d  = step_res;
        op_b_d = {op_b_q[W-2:0], 1'b0};
        step_d = step_q + rbm_pkg::STEP_W'(1);
      end
      rbm_pkg::ST_NEXT: begin
        acc_d  = '0;
        step_d = '0;
        case (phase_q)
          rbm_pkg::PH_REDUCE: begin
            base_d  = acc_q;
            op_a_d  = r_q;
            op_b_d  = r_q;
            phase_d = rbm_pkg::PH_SQUARE;
          end
          rbm_pkg::PH_SQUARE: begin
            r_d = acc_q;
            if (exp_q[W-1]) begin
              op_a_d  = base_q;
              op_b_d  = acc_q;
              phase_d = rbm_pkg::PH_MULT;
            end else begin
              exp_d   = {exp_q[W-2:0], 1'b0};
              iter_d  = iter_q + rbm_pkg::STEP_W'(1);
              op_a_d  = acc_q;
              op_b_d  = acc_q;
              phase_d = rbm_pkg::PH_SQUARE;
            end
          end
          rbm_pkg::PH_MULT: begin
            r_d     = acc_q;
            exp_d   = {exp_q[W-2:0], 1'b0};
            iter_d  = iter_q + rbm_pkg::STEP_W'(1);
            op_a_d  = acc_q;
            op_b_d  = acc_q;
            phase_d = rbm_pkg::PH_SQUARE;
          end
          default: phase_d = rbm_pkg::PH_SQUARE;
        endcase
      end
      rbm_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          cipher_d    = (cmd_q == rbm_pkg::CMD_ENCRYPT) ? r_q : '0;
          plain_d     = (cmd_q == rbm_pkg::CMD_DECRYPT) ? plain_word : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rbm_pkg::ST_IDLE;
      phase_q     <= rbm_pkg::PH_REDUCE;
      step_q      <= '0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      step_q      <= step_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    acc_q    <= acc_d;
    op_a_q   <= op_a_d;
    op_b_q   <= op_b_d;
    base_q   <= base_d;
    r_q      <= r_d;
    exp_q    <= exp_d;
    cipher_q <= cipher_d;
    plain_q  <= plain_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.cipher_out = cipher_q;
  assign out_o.plain_out  = plain_q;

endmodule
